// ----- src/gga_pkg.sv -----
// Package for the greedy gap splitting allocator.
// Beat types, gap table entry, sequencer states and shared widths.
// No dependencies.
package gga_pkg;

  localparam int POS_W          = 32;
  localparam int CNT_W          = 20;
  localparam int DIV_W          = 21;
  localparam int FRAC_W         = 16;
  localparam int FIX_W          = POS_W + FRAC_W;
  localparam int PROD_W         = POS_W + DIV_W;
  localparam int DIV_CNT_W      = $clog2(FIX_W);
  localparam int MAX_POINTS_DEF = 1024;

  // input beat: one station position
  typedef struct packed {
    logic [POS_W-1:0] position;
    logic             last_point;
  } in_beat_t;

  // result beat
  typedef struct packed {
    logic [POS_W-1:0] gap_numerator;
    logic [DIV_W-1:0] gap_divisor;
    logic [FIX_W-1:0] max_distance_fixed;
    logic             too_few_points;
  } out_beat_t;

  // one gap: original length and stations placed in it
  typedef struct packed {
    logic [POS_W-1:0] gap;
    logic [CNT_W-1:0] placed;
  } gap_entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_MUL1,
    S_MUL2,
    S_CMP,
    S_PLACE,
    S_DIV_SETUP,
    S_DIV,
    S_FINISH
  } state_t;

endpackage

// ----- src/greedy_gap_splitting_allocator.sv -----
// Greedy gap splitting allocator: top level, sequencer, gap table, divider.
// Depends on gga_pkg.
//
// Positions load one beat per cycle while idle; each new position writes the
// gap to the previous one into a gap table, so no clearing pass is needed.
// The beat with last_point starts placement: for each of stations_to_place
// stations, one scan over all G gaps (each gap passing through S_READ,
// S_MUL1, S_MUL2 and S_CMP, set by the single shared 53-bit multiplier used
// twice per gap and the one table read port) finds the gap with the largest
// gap/(placed+1), ties to the higher index, followed by a write-back step in
// S_PLACE. A final scan picks the reported gap and a bit-serial divider forms
// the fixed-point value. in_stall is high from the last beat until the result
// is handed to the output register. With fewer than two positions the
// sequencer goes from the last beat straight to S_FINISH and registers a
// result with too_few_points set. The result is held in an output register,
// so loading of the next run may start while it waits to be taken.
module greedy_gap_splitting_allocator
  import gga_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [CNT_W-1:0] cfg_wr_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_beat_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_beat_t        out_data
);

  localparam int PCW   = $clog2(MAX_POINTS + 1);
  localparam int GAW   = (MAX_POINTS > 2) ? $clog2(MAX_POINTS - 1) : 1;
  localparam int GAPS  = MAX_POINTS - 1;

  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(FIX_W - 1);

  state_t state, state_next;

  logic [CNT_W-1:0] stations_to_place;
  logic [PCW-1:0]   points_loaded;
  logic [CNT_W-1:0] stations_done;
  logic [POS_W-1:0] prev_pos;
  logic             too_few;

  // gap table
  gap_entry_t       gap_mem [GAPS];
  gap_entry_t       rd_data;
  logic             mem_we;
  logic [GAW-1:0]   mem_waddr;
  gap_entry_t       mem_wdata;

  // scan datapath
  logic [GAW-1:0]    scan_idx;
  logic [GAW-1:0]    best_idx;
  logic [POS_W-1:0]  best_gap;
  logic [CNT_W-1:0]  best_placed;
  logic [PROD_W-1:0] prod_a;
  logic [PROD_W-1:0] prod_b;
  logic [POS_W-1:0]  mul_x;
  logic [DIV_W-1:0]  mul_y;
  logic [PROD_W-1:0] mul_p;
  logic              scan_last;
  logic              take;

  // divider
  logic [FIX_W-1:0]     quo;
  logic [DIV_W-1:0]     rem;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [DIV_W-1:0]     divisor;
  logic [DIV_W:0]       rem_shift;
  logic                 rem_ge;

  logic             in_fire;
  logic             out_free;
  logic             can_store;
  logic [PCW-1:0]   loaded_after;
  logic             too_few_now;
  logic             more_stations;

  assign in_stall  = (state != S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign can_store = (points_loaded < PCW'(MAX_POINTS));

  assign loaded_after  = can_store ? points_loaded + PCW'(1) : points_loaded;
  assign too_few_now   = (loaded_after < PCW'(2));
  assign more_stations = (stations_done < stations_to_place);

  assign scan_last = (PCW'(scan_idx) == points_loaded - PCW'(2));
  assign take      = (scan_idx == '0) || (prod_a >= prod_b);

  // shared multiplier: candidate side first, then incumbent side
  assign mul_x = (state == S_MUL1) ? rd_data.gap : best_gap;
  assign mul_y = (state == S_MUL1) ? {1'b0, best_placed} + DIV_W'(1)
                                   : {1'b0, rd_data.placed} + DIV_W'(1);
  assign mul_p = PROD_W'(mul_x) * PROD_W'(mul_y);

  assign divisor   = {1'b0, best_placed} + DIV_W'(1);
  assign rem_shift = {rem, quo[FIX_W-1]};
  assign rem_ge    = (rem_shift >= {1'b0, divisor});

  // table write: new gap at load, bumped count at placement
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = best_idx;
    mem_wdata = '{gap: best_gap, placed: best_placed + CNT_W'(1)};
    if (state == S_PLACE) begin
      mem_we = 1'b1;
    end else if (in_fire && can_store && (points_loaded != '0)) begin
      mem_we    = 1'b1;
      mem_waddr = GAW'(points_loaded - PCW'(1));
      mem_wdata = '{gap: in_data.position - prev_pos, placed: '0};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      gap_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= gap_mem[scan_idx];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_fire && in_data.last_point) begin
          state_next = too_few_now ? S_FINISH : S_READ;
        end
      end
      S_READ:  state_next = S_MUL1;
      S_MUL1:  state_next = S_MUL2;
      S_MUL2:  state_next = S_CMP;
      S_CMP: begin
        if (scan_last) begin
          state_next = more_stations ? S_PLACE : S_DIV_SETUP;
        end else begin
          state_next = S_READ;
        end
      end
      S_PLACE:     state_next = S_READ;
      S_DIV_SETUP: state_next = S_DIV;
      S_DIV: begin
        if (div_cnt == DIV_LAST) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      stations_to_place <= '0;
      points_loaded     <= '0;
      stations_done     <= '0;
      out_valid         <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        stations_to_place <= cfg_wr_data;
      end
      if (in_fire) begin
        points_loaded <= loaded_after;
      end
      if (state == S_PLACE) begin
        stations_done <= stations_done + CNT_W'(1);
      end
      if (state == S_FINISH && out_free) begin
        points_loaded <= '0;
        stations_done <= '0;
        out_valid     <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_fire && can_store) begin
      prev_pos <= in_data.position;
    end
    if (in_fire && in_data.last_point) begin
      too_few <= too_few_now;
    end

    // scan over gaps
    unique case (state)
      S_IDLE:  scan_idx <= '0;
      S_PLACE: scan_idx <= '0;
      S_CMP: begin
        if (!scan_last) begin
          scan_idx <= scan_idx + GAW'(1);
        end
      end
      default: scan_idx <= scan_idx;
    endcase
    if (state == S_MUL1) begin
      prod_a <= mul_p;
    end
    if (state == S_MUL2) begin
      prod_b <= mul_p;
    end
    if (state == S_CMP && take) begin
      best_idx    <= scan_idx;
      best_gap    <= rd_data.gap;
      best_placed <= rd_data.placed;
    end

    // restoring divider, one quotient bit per cycle
    if (state == S_DIV_SETUP) begin
      quo     <= {best_gap, FRAC_W'(0)};
      rem     <= '0;
      div_cnt <= '0;
    end else if (state == S_DIV) begin
      quo     <= {quo[FIX_W-2:0], rem_ge};
      rem     <= rem_ge ? DIV_W'(rem_shift - {1'b0, divisor}) : DIV_W'(rem_shift);
      div_cnt <= div_cnt + DIV_CNT_W'(1);
    end

    // result beat
    if (state == S_FINISH && out_free) begin
      if (too_few) begin
        out_data <= '{gap_numerator: '0, gap_divisor: DIV_W'(1),
                      max_distance_fixed: '0, too_few_points: 1'b1};
      end else begin
        out_data <= '{gap_numerator: best_gap, gap_divisor: divisor,
                      max_distance_fixed: quo, too_few_points: 1'b0};
      end
    end
  end

`ifndef NO_ASSERTIONS
  // divider remainder stays below the divisor
  assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> ({1'b0, rem} < {1'b0, divisor}))
    else $error("divider remainder out of range");

  // a placement never exceeds the configured station count
  assert property (@(posedge clk) disable iff (rst)
    (state == S_PLACE) |-> (stations_done < stations_to_place))
    else $error("too many stations placed");

  // scanning only with at least two loaded points and in range
  assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> ((points_loaded >= PCW'(2)) &&
                           (PCW'(scan_idx) <= points_loaded - PCW'(2))))
    else $error("scan index beyond loaded gaps");

  // every result carries a nonzero divisor
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.gap_divisor != '0))
    else $error("zero divisor in result beat");
`endif

endmodule

// ----- test/greedy_gap_splitting_allocator_test.sv -----
// Self-checking testbench for greedy_gap_splitting_allocator: directed and random runs of
// positions, sorted or not, results checked against an in-bench apportionment predictor.
// Depends on gga_pkg and the greedy_gap_splitting_allocator RTL.
`timescale 1ns / 1ps

module greedy_gap_splitting_allocator_test;
  import gga_pkg::*;

  localparam int MAX_PTS  = MAX_POINTS_DEF;
  localparam int LIMIT    = 3_000_000;
  localparam int SETTLE   = 8;
  localparam int TAIL     = 60;
  localparam int MAX_SHOW = 50;

  typedef enum {SHAPE_SORTED, SHAPE_EVEN, SHAPE_SCATTERED} run_shape_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_wr_en = 1'b0;
  logic [CNT_W-1:0] cfg_wr_data = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  in_beat_t         in_data = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_beat_t        out_data;

  // predictor state
  bit [POS_W-1:0]   pos_store [MAX_PTS];
  int unsigned      pts_loaded = 0;
  bit [CNT_W-1:0]   stations_cfg = '0;

  in_beat_t         pending_beats [$];
  out_beat_t        expected_beats [$];
  out_beat_t        got_beat, want_beat;
  int               beats_queued = 0;
  int               beats_taken = 0;
  logic             in_beat_taken = 1'b0;
  int               mismatches = 0;
  int               cycle_count = 0;
  int               send_idle_pct = 0;
  int               stall_pct = 0;
  int               hold_left = 0;

  greedy_gap_splitting_allocator uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report(input string msg);
    if (mismatches < MAX_SHOW) $display("MISMATCH @%0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  // Load one position; on the closing beat place the stations greedily and queue the result.
  function automatic void track_beat(input in_beat_t b);
    bit [POS_W-1:0]  gap_len [MAX_PTS];
    int unsigned     placed [MAX_PTS];
    int unsigned     n_gaps;
    int unsigned     best;
    longint unsigned lhs, rhs, num, div;
    out_beat_t       r;
    if (pts_loaded < MAX_PTS) begin
      pos_store[pts_loaded] = b.position;
      pts_loaded++;
    end
    if (!b.last_point) return;
    r = '0;
    r.gap_divisor = DIV_W'(1);
    if (pts_loaded < 2) begin
      r.too_few_points = 1'b1;
    end else begin
      n_gaps = pts_loaded - 1;
      // gaps wrap modulo 2^32 when positions go backwards
      for (int i = 0; i < n_gaps; i++) begin
        gap_len[i] = pos_store[i+1] - pos_store[i];
        placed[i] = 0;
      end
      // one scan per station, plus a last scan for the reported gap
      for (int s = 0; s <= int'(stations_cfg); s++) begin
        best = 0;
        for (int i = 1; i < n_gaps; i++) begin
          lhs = 64'(gap_len[i]) * (64'(placed[best]) + 1);
          rhs = 64'(gap_len[best]) * (64'(placed[i]) + 1);
          if (lhs >= rhs) best = i;  // equal quotients: higher index wins
        end
        if (s < int'(stations_cfg)) placed[best]++;
      end
      num = 64'(gap_len[best]);
      div = 64'(placed[best]) + 1;
      r.gap_numerator      = gap_len[best];
      r.gap_divisor        = DIV_W'(div);
      r.max_distance_fixed = FIX_W'((num << FRAC_W) / div);
    end
    expected_beats.push_back(r);
    pts_loaded = 0;
  endfunction

  task automatic push_beat(input bit [POS_W-1:0] pos, input bit last);
    in_beat_t b;
    b.position   = pos;
    b.last_point = last;
    pending_beats.push_back(b);
    beats_queued++;
  endtask

  // Wait until every queued beat is taken and every result has come back.
  task automatic wait_quiet();
    do @(negedge clk);
    while (!(beats_taken == beats_queued && expected_beats.size() == 0));
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_station_budget(input int unsigned n);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= CNT_W'(n);
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Driver: new beat at the falling edge once the previous one is taken.
  always @(negedge clk) begin
    if (!rst && (!in_valid || in_beat_taken)) begin
      if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data  <= pending_beats.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, or a long hold-off while hold_left runs down.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Monitor: track config and input beats, check result beats.
  always @(posedge clk) begin
    in_beat_taken <= in_valid && !in_stall;
    if (!rst) begin
      if (cfg_wr_en) stations_cfg = cfg_wr_data;
      if (in_valid && !in_stall) begin
        track_beat(in_data);
        beats_taken++;
      end
      if (out_valid && !out_stall) begin
        got_beat = out_data;
        if (expected_beats.size() == 0) begin
          report("result beat with nothing expected");
        end else begin
          want_beat = expected_beats.pop_front();
          if (got_beat.gap_numerator !== want_beat.gap_numerator)
            report($sformatf("gap_numerator %0h, want %0h",
                             got_beat.gap_numerator, want_beat.gap_numerator));
          if (got_beat.gap_divisor !== want_beat.gap_divisor)
            report($sformatf("gap_divisor %0d, want %0d",
                             got_beat.gap_divisor, want_beat.gap_divisor));
          if (got_beat.max_distance_fixed !== want_beat.max_distance_fixed)
            report($sformatf("max_distance_fixed %0h, want %0h",
                             got_beat.max_distance_fixed, want_beat.max_distance_fixed));
          if (got_beat.too_few_points !== want_beat.too_few_points)
            report($sformatf("too_few_points %0b, want %0b",
                             got_beat.too_few_points, want_beat.too_few_points));
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("greedy_gap_splitting_allocator_test NOT OK");
      $finish;
    end
  end

  initial begin
    bit [POS_W-1:0] run_pos [$];
    run_shape_t     shape;
    int             made, n, roll, shift;
    bit [POS_W-1:0] base, step;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: single point with the reset budget of zero
    push_beat(32'h1234_5678, 1'b1);
    wait_quiet();
    // widest possible gap, no stations
    set_station_budget(0);
    push_beat(32'h0000_0000, 1'b0);
    push_beat(32'hFFFF_FFFF, 1'b1);
    wait_quiet();
    // positions going backwards wrap around
    push_beat(32'hFFFF_FFFF, 1'b0);
    push_beat(32'h0000_0000, 1'b1);
    wait_quiet();
    // long receiver hold-off over short runs so the block backs up into its input
    @(posedge clk);
    hold_left = 400;
    for (int i = 0; i < 12; i++)
      push_beat(POS_W'(i * 3 + (i % 4) * 11), (i % 2) == 1);
    wait_quiet();
    // equal gaps: ties go to the higher index
    set_station_budget(3);
    push_beat(32'd10, 1'b0);
    push_beat(32'd20, 1'b0);
    push_beat(32'd30, 1'b1);
    wait_quiet();
    // duplicate positions, all gaps zero
    push_beat(32'd5, 1'b0);
    push_beat(32'd5, 1'b0);
    push_beat(32'd5, 1'b1);
    wait_quiet();
    set_station_budget(2);
    push_beat(32'h0000_0000, 1'b0);
    push_beat(32'h0000_0064, 1'b0);
    push_beat(32'h8000_0000, 1'b0);
    push_beat(32'hFFFF_FFFF, 1'b1);
    wait_quiet();
    // largest budget with too few points
    set_station_budget(20'hFFFFF);
    push_beat(32'hAAAA_5555, 1'b1);
    wait_quiet();
    // large budget into one gap
    set_station_budget(40000);
    push_beat(32'h0000_0000, 1'b0);
    push_beat(32'hFFFF_FFFF, 1'b1);
    wait_quiet();
    // run longer than the store: extra positions are dropped
    set_station_budget(2);
    for (int i = 0; i < MAX_PTS + 2; i++)
      push_beat(POS_W'(i * 7 + (i % 5) * 1000), i == MAX_PTS + 1);
    wait_quiet();

    // Random runs in four idling phases, budget changed between blocks
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = (phase == 1) ? 53 : (phase == 3) ? 36 : 0;
      stall_pct     = (phase == 2) ? 53 : (phase == 3) ? 36 : 0;
      for (int blk = 0; blk < 4; blk++) begin
        roll = $urandom_range(99);
        if (roll < 50)      set_station_budget($urandom_range(3));
        else if (roll < 90) set_station_budget($urandom_range(4, 16));
        else                set_station_budget($urandom_range(17, 64));
        made = 0;
        while (made < 16) begin
          roll = $urandom_range(99);
          if (roll < 8)       n = 1;
          else if (roll < 90) n = $urandom_range(2, 12);
          else                n = $urandom_range(13, 48);
          roll = $urandom_range(99);
          shape = (roll < 70) ? SHAPE_SORTED : (roll < 85) ? SHAPE_EVEN : SHAPE_SCATTERED;
          run_pos.delete();
          shift = $urandom_range(31);
          base  = $urandom_range(32'hFFFF_0000);
          step  = $urandom_range(4095);
          for (int i = 0; i < n; i++) begin
            case (shape)
              SHAPE_SORTED: begin
                if (i > 0 && $urandom_range(7) == 0) run_pos.push_back(run_pos[i-1]);
                else run_pos.push_back($urandom >> shift);
              end
              SHAPE_EVEN: begin
                run_pos.push_back(base + POS_W'(i) * step);
              end
              default: begin
                run_pos.push_back($urandom);
              end
            endcase
          end
          if (shape == SHAPE_SORTED) run_pos.sort();
          for (int i = 0; i < n; i++) push_beat(run_pos[i], i == n - 1);
          made += n;
        end
        wait_quiet();
      end
    end

    // catch any stray result beats
    repeat (TAIL) @(negedge clk);
    if (mismatches == 0) begin
      $display("greedy_gap_splitting_allocator_test OK");
    end else begin
      $display("greedy_gap_splitting_allocator_test NOT OK");
    end
    $finish;
  end

endmodule

// ----- greedy_gap_splitting_allocator.f -----
src/gga_pkg.sv
src/greedy_gap_splitting_allocator.sv
test/greedy_gap_splitting_allocator_test.sv
